@@ rtl/llq_pkg.sv @@
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types and constants of the linked list queue manager: transfer
// structs of both channels, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llq_pkg;

  // Default geometry
  localparam int unsigned SlotsDefault     = 64;
  localparam int unsigned DataWidthDefault = 32;

  // Operation codes
  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_REMOVE     = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_LINK,
    S_POP_WAIT,
    S_WALK,
    S_UNLINK,
    S_FRONT_RD,
    S_RESULT
  } state_e;

  // Input transfer
  typedef struct packed {
    kind_e       kind;
    logic [31:0] item_data;
    logic [5:0]  item_handle;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    status_e     status;
    logic [5:0]  slot_handle;
    logic [31:0] front_data;
    logic [5:0]  front_handle;
    logic [6:0]  item_count;
    logic        is_empty;
  } out_item_t;

endpackage

@@ rtl/llq_ram.sv @@
// ----------------------------------------------------------------------------
// llq_ram
// Simple dual port synchronous RAM: one write port, one registered read
// port. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/linked_list_queue_manager.sv @@
// ----------------------------------------------------------------------------
// linked_list_queue_manager
// Singly linked queue over a fixed pool of slots, payloads and links kept
// in synchronous RAMs, with a per-slot used bitmap in flops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one
//   operation: push back, push front, pop front or remove by handle.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns one
//   result per operation: status, slot handle, head payload and handle,
//   element count and empty flag.
//   Steps from input transfer to result: a rejected operation, push front
//   or push into an empty queue go through decode, payload read and result;
//   push back adds a link write of the new slot, pop and remove of the head
//   add a step that advances the head, and remove of any other element adds
//   a walk from the head, one link read per cycle, and an unlink step. The
//   link and payload RAMs have registered read ports: data of a read comes in the cycle after it.
//   One operation is in flight at a time; the next is taken as soon as the
//   result sits in the output register.
//   Reset clears the used bitmap, head, tail and count; the RAMs need no
//   clearing pass, the block is ready as soon as reset is released.
//   While the receiver stalls, the result is held, and the sequencer waits
//   in its final step once a second result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_list_queue_manager #(
  parameter int unsigned SLOTS      = llq_pkg::SlotsDefault,
  parameter int unsigned DATA_WIDTH = llq_pkg::DataWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  llq_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output llq_pkg::out_item_t out_item_o
);

  import llq_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  // State registers
  state_e              state_q, state_d;
  in_item_t            op_q, op_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SLOTS-1:0]    used_q, used_d;
  logic [IDX_W-1:0]    free_slot_q, free_slot_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    prev_q, prev_d;
  logic [CNT_W-1:0]    steps_q, steps_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  // RAM ports
  logic                  nl_we, nl_re, pl_we, pl_re;
  logic [IDX_W-1:0]      nl_waddr, nl_raddr, pl_waddr, pl_raddr;
  logic [IDX_W-1:0]      nl_wdata, nl_rdata;
  logic [DATA_WIDTH-1:0] pl_wdata, pl_rdata;

  // Derived operand views
  logic [IDX_W+5:0]      handle_pad;
  logic [IDX_W-1:0]      handle_ix;
  logic                  handle_ok;
  logic                  handle_used;
  logic [DATA_WIDTH+31:0] data_in_pad;
  logic [DATA_WIDTH+31:0] data_out_pad;
  logic [IDX_W+5:0]      slot_pad, head_pad;
  logic [CNT_W+6:0]      count_pad;
  logic [CNT_W-1:0]      steps_inc;

  assign handle_pad   = {{IDX_W{1'b0}}, op_q.item_handle};
  assign handle_ix    = handle_pad[IDX_W-1:0];
  assign handle_ok    = ({26'd0, op_q.item_handle} < 32'(SLOTS));
  assign handle_used  = handle_ok && used_q[handle_ix];
  assign data_in_pad  = {{DATA_WIDTH{1'b0}}, op_q.item_data};
  assign data_out_pad = {32'd0, pl_rdata};
  assign slot_pad     = {6'd0, slot_q};
  assign head_pad     = {6'd0, head_q};
  assign count_pad    = {7'd0, count_q};
  assign steps_inc    = steps_q + CNT_W'(1);

  // Payload and link stores
  llq_ram #(
    .Width (DATA_WIDTH),
    .Depth (SLOTS)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (pl_wdata),
    .re_i    (pl_re),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  llq_ram #(
    .Width (IDX_W),
    .Depth (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .re_i    (nl_re),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  // Lowest free slot, registered; settled long before the next decode
  always_comb begin
    free_slot_d = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot_d = IDX_W'(i);
      end
    end
  end

  // Sequencer: next state, bookkeeping and RAM accesses
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    used_d      = used_q;
    slot_d      = slot_q;
    status_d    = status_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q & out_stall_i;
    nl_we       = 1'b0;
    nl_waddr    = '0;
    nl_wdata    = '0;
    nl_re       = 1'b0;
    nl_raddr    = '0;
    pl_we       = 1'b0;
    pl_waddr    = '0;
    pl_wdata    = data_in_pad[DATA_WIDTH-1:0];
    pl_re       = 1'b0;
    pl_raddr    = head_q;
    in_stall_o  = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = ST_OK;
        slot_d   = '0;
        state_d  = S_FRONT_RD;
        unique case (op_q.kind)
          KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (count_q == CNT_W'(SLOTS)) begin
              status_d = ST_FULL;
            end else begin
              slot_d              = free_slot_q;
              used_d[free_slot_q] = 1'b1;
              count_d             = count_q + CNT_W'(1);
              pl_we               = 1'b1;
              pl_waddr            = free_slot_q;
              nl_we               = 1'b1;
              priority if (count_q == '0) begin
                // first element: head and tail both
                nl_waddr = free_slot_q;
                nl_wdata = '0;
                head_d   = free_slot_q;
                tail_d   = free_slot_q;
              end else if (op_q.kind == KIND_PUSH_BACK) begin
                // old tail links to new slot; new slot's link next cycle
                nl_waddr = tail_q;
                nl_wdata = free_slot_q;
                tail_d   = free_slot_q;
                state_d  = S_PUSH_LINK;
              end else begin
                nl_waddr = free_slot_q;
                nl_wdata = head_q;
                head_d   = free_slot_q;
              end
            end
          end

          KIND_POP_FRONT: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              slot_d   = head_q;
              nl_re    = 1'b1;
              nl_raddr = head_q;
              state_d  = S_POP_WAIT;
            end
          end

          KIND_REMOVE: begin
            priority if (!handle_used || count_q == '0) begin
              status_d = ST_NOT_FOUND;
            end else if (handle_ix == head_q) begin
              slot_d   = head_q;
              nl_re    = 1'b1;
              nl_raddr = head_q;
              state_d  = S_POP_WAIT;
            end else if (count_q > CNT_W'(1)) begin
              // walk from the head, one link read per cycle
              prev_d   = head_q;
              steps_d  = CNT_W'(1);
              nl_re    = 1'b1;
              nl_raddr = head_q;
              state_d  = S_WALK;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end

          default: begin
            status_d = ST_NOT_FOUND;
          end
        endcase
      end

      S_PUSH_LINK: begin
        nl_we    = 1'b1;
        nl_waddr = slot_q;
        nl_wdata = '0;
        state_d  = S_FRONT_RD;
      end

      S_POP_WAIT: begin
        // head advances to the link of the freed slot
        used_d[slot_q] = 1'b0;
        count_d        = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = nl_rdata;
        end
        state_d = S_FRONT_RD;
      end

      S_WALK: begin
        priority if (nl_rdata == handle_ix) begin
          slot_d   = handle_ix;
          nl_re    = 1'b1;
          nl_raddr = handle_ix;
          state_d  = S_UNLINK;
        end else if (steps_inc < count_q) begin
          prev_d   = nl_rdata;
          steps_d  = steps_inc;
          nl_re    = 1'b1;
          nl_raddr = nl_rdata;
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_FRONT_RD;
        end
      end

      S_UNLINK: begin
        // predecessor takes over the removed slot's link
        nl_we          = 1'b1;
        nl_waddr       = prev_q;
        nl_wdata       = nl_rdata;
        used_d[slot_q] = 1'b0;
        count_d        = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else if (slot_q == tail_q) begin
          tail_d = prev_q;
        end
        state_d = S_FRONT_RD;
      end

      S_FRONT_RD: begin
        pl_re   = 1'b1;
        state_d = S_RESULT;
      end

      S_RESULT: begin
        // load the output register once it is free or draining
        if (!out_valid_q || !out_stall_i) begin
          out_item_d.status      = status_q;
          out_item_d.slot_handle = slot_pad[5:0];
          out_item_d.item_count  = count_pad[6:0];
          if (count_q == '0) begin
            out_item_d.front_data   = '0;
            out_item_d.front_handle = '0;
            out_item_d.is_empty     = 1'b1;
          end else begin
            out_item_d.front_data   = data_out_pad[31:0];
            out_item_d.front_handle = head_pad[5:0];
            out_item_d.is_empty     = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      free_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      used_q      <= used_d;
      free_slot_q <= free_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation and result payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    status_q   <= status_d;
    prev_q     <= prev_d;
    steps_q    <= steps_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("element count above slot pool size");

  a_bitmap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(used_q) == int'(count_q)))
    else $error("used bitmap disagrees with element count");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with non-zero head or tail");

  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE && count_q != CNT_W'(SLOTS)) |-> !used_q[free_slot_q])
    else $error("free slot pointer names a used slot");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked list queue manager. A behavioural
// model of the queue predicts each result at the moment its operation is
// accepted. A checker compares every result transfer, field by field, with
// the oldest prediction. Stimulus is a directed pass over the corner cases,
// then a fill to full, a drain to empty and biased random phases. Both
// channels insert random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import llq_pkg::*;

  localparam int unsigned Slots       = 64;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned MaxGap      = 17;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned ReportMax   = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Model of the queue
  logic [31:0] slot_data [Slots];
  logic [5:0]  slot_next [Slots];
  bit          slot_busy [Slots];
  logic [5:0]  q_head;
  logic [5:0]  q_tail;
  int unsigned q_count;

  out_item_t   pending_results[$];
  int unsigned mismatch_cnt;
  bit          gaps_on;
  int unsigned stall_left;

  linked_list_queue_manager #(
    .SLOTS      (Slots),
    .DATA_WIDTH (DataWidth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the model and return the result it should give
  function automatic out_item_t apply_op(in_item_t op);
    out_item_t   res;
    int unsigned slot;
    int unsigned prev;
    int unsigned cur;
    int unsigned steps;
    bit          freed;
    res        = '0;
    res.status = ST_OK;
    slot       = 0;
    freed      = 1'b0;
    case (op.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (q_count >= Slots) begin
          res.status = ST_FULL;
        end else begin
          // lowest free slot
          while (slot_busy[slot]) slot++;
          slot_busy[slot] = 1'b1;
          slot_data[slot] = op.item_data;
          if (q_count == 0) begin
            slot_next[slot] = '0;
            q_head          = 6'(slot);
            q_tail          = 6'(slot);
          end else if (op.kind == KIND_PUSH_BACK) begin
            slot_next[q_tail] = 6'(slot);
            slot_next[slot]   = '0;
            q_tail            = 6'(slot);
          end else begin
            slot_next[slot] = q_head;
            q_head          = 6'(slot);
          end
          q_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (q_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot   = q_head;
          q_head = slot_next[slot];
          freed  = 1'b1;
        end
      end
      default: begin
        if (q_count == 0 || !slot_busy[op.item_handle]) begin
          res.status = ST_NOT_FOUND;
        end else if (op.item_handle == q_head) begin
          slot   = q_head;
          q_head = slot_next[slot];
          freed  = 1'b1;
        end else begin
          // walk from the head to find the predecessor
          prev  = q_head;
          steps = 1;
          while (steps < q_count && !freed) begin
            cur = slot_next[prev];
            if (cur == op.item_handle) begin
              freed = 1'b1;
            end else begin
              prev = cur;
              steps++;
            end
          end
          if (!freed) begin
            res.status = ST_NOT_FOUND;
          end else begin
            slot            = op.item_handle;
            slot_next[prev] = slot_next[slot];
            if (slot == q_tail) q_tail = 6'(prev);
          end
        end
      end
    endcase
    if (freed) begin
      slot_busy[slot] = 1'b0;
      q_count--;
      if (q_count == 0) begin
        q_head = '0;
        q_tail = '0;
      end
    end
    res.slot_handle = 6'(slot);
    if (q_count != 0) begin
      res.front_data   = slot_data[q_head];
      res.front_handle = q_head;
    end
    res.item_count = 7'(q_count);
    res.is_empty   = (q_count == 0);
    return res;
  endfunction

  function automatic in_item_t mk_op(kind_e k, logic [31:0] d, logic [5:0] h);
    in_item_t op;
    op.kind        = k;
    op.item_data   = d;
    op.item_handle = h;
    return op;
  endfunction

  // Random operation; removes mostly aim at live slots
  function automatic in_item_t rand_op(int unsigned push_pct, int unsigned pop_pct);
    in_item_t    op;
    int unsigned roll;
    int unsigned live[$];
    op.item_data   = $urandom();
    op.item_handle = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 15))
      0:       op.item_data = '0;
      1:       op.item_data = '1;
      default: ;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      op.kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    end else if (roll < push_pct + pop_pct) begin
      op.kind = KIND_POP_FRONT;
    end else begin
      op.kind = KIND_REMOVE;
      for (int i = 0; i < Slots; i++) begin
        if (slot_busy[i]) live.push_back(i);
      end
      if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
        op.item_handle = 6'(live[$urandom_range(0, live.size() - 1)]);
      end
    end
    return op;
  endfunction

  // Send one operation; valid stays high across back-to-back transfers
  task automatic send_op(input in_item_t op);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_op(op));
  endtask

  // Corner cases: empty queue, both push kinds, removal of head, middle and
  // tail, unused handles, handle and data extremes
  task automatic test_directed_cases();
    gaps_on = 1'b1;
    send_op(mk_op(KIND_POP_FRONT,  32'h0,        6'd0));   // pop of empty queue
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd0));   // remove on empty queue
    send_op(mk_op(KIND_REMOVE,     32'hFFFFFFFF, 6'd63));
    send_op(mk_op(KIND_PUSH_BACK,  32'h0,        6'd63));  // first element
    send_op(mk_op(KIND_PUSH_BACK,  32'hFFFFFFFF, 6'd0));
    send_op(mk_op(KIND_PUSH_FRONT, 32'hA5A5A5A5, 6'd0));
    send_op(mk_op(KIND_PUSH_BACK,  32'h5A5A5A5A, 6'd0));   // list 2,0,1,3
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd0));   // middle
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd3));   // tail, tail moves back
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd63));  // never used
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd0));   // already freed
    send_op(mk_op(KIND_PUSH_BACK,  32'h12345678, 6'd0));   // append after new tail
    send_op(mk_op(KIND_PUSH_FRONT, 32'h0F0F0F0F, 6'd0));
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd3));   // head
    send_op(mk_op(KIND_POP_FRONT,  32'h0,        6'd0));
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd0));   // tail
    send_op(mk_op(KIND_REMOVE,     32'h0,        6'd1));   // last element
    send_op(mk_op(KIND_PUSH_FRONT, 32'hFFFFFFFF, 6'd0));   // push front into empty
    send_op(mk_op(KIND_POP_FRONT,  32'h0,        6'd0));
    send_op(mk_op(KIND_POP_FRONT,  32'h0,        6'd0));
  endtask

  // Push until the store is full, then a few more to hit the full status
  task automatic test_fill_to_full();
    gaps_on = 1'b1;
    repeat (Slots - q_count + 3) send_op(rand_op(100, 0));
  endtask

  // Pops and removes until empty, then one of each on the empty queue
  task automatic test_drain_to_empty();
    gaps_on = 1'b0;
    while (q_count != 0) send_op(rand_op(0, 40));
    send_op(rand_op(0, 100));
    send_op(rand_op(0, 0));
  endtask

  // Phases biased towards filling, draining and balance; some without gaps
  task automatic test_random_mix();
    for (int p = 0; p < 8; p++) begin
      gaps_on = (p % 3 != 2);
      case (p % 3)
        0:       repeat (120) send_op(rand_op(75, 10));
        1:       repeat (120) send_op(rand_op(20, 35));
        default: repeat (120) send_op(rand_op(45, 25));
      endcase
    end
  endtask

  // Result checker and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax) begin
            $display("%0t: result with none expected: status=%0d slot=%0d", $realtime,
                     out_item_o.status, out_item_o.slot_handle);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.status !== want.status ||
              out_item_o.slot_handle !== want.slot_handle ||
              out_item_o.front_data !== want.front_data ||
              out_item_o.front_handle !== want.front_handle ||
              out_item_o.item_count !== want.item_count ||
              out_item_o.is_empty !== want.is_empty) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportMax) begin
              $display("%0t: expected status=%0d slot=%0d front=%h@%0d count=%0d empty=%0b",
                       $realtime, want.status, want.slot_handle, want.front_data,
                       want.front_handle, want.item_count, want.is_empty);
              $display("%0t:   actual status=%0d slot=%0d front=%h@%0d count=%0d empty=%0b",
                       $realtime, out_item_o.status, out_item_o.slot_handle,
                       out_item_o.front_data, out_item_o.front_handle,
                       out_item_o.item_count, out_item_o.is_empty);
            end
          end
        end
        stall_left = gaps_on ? $urandom_range(0, MaxGap) : 0;
        out_stall_i <= (stall_left != 0);
      end else if (out_stall_i) begin
        if (stall_left > 1) begin
          stall_left--;
        end else begin
          stall_left = 0;
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Test sequence
  initial begin
    mismatch_cnt = 0;
    gaps_on      = 1'b1;
    q_head       = '0;
    q_tail       = '0;
    q_count      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_fill_to_full();
    test_drain_to_empty();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/llq_pkg.sv
rtl/llq_ram.sv
rtl/linked_list_queue_manager.sv
sim/testbench.sv
